// ===== hdl/frr_pkg.sv =====
package frr_pkg;

  localparam int PAYLOAD_MAX = 48;

  localparam logic [15:0] GAP_LIMIT_RESET   = 16'd100;
  localparam logic [5:0]  MAX_PAYLOAD_RESET = 6'd48;
  localparam logic [7:0]  SYNC_FIRST_RESET  = 8'hAB;
  localparam logic [7:0]  SYNC_SECOND_RESET = 8'hCD;

  localparam logic [1:0] REG_GAP_LIMIT   = 2'd0;
  localparam logic [1:0] REG_MAX_PAYLOAD = 2'd1;
  localparam logic [1:0] REG_SYNC_FIRST  = 2'd2;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd3;

  localparam logic [1:0] MODE_BYTE = 2'd0;
  localparam logic [1:0] MODE_TICK = 2'd1;
  localparam logic [1:0] MODE_ARM  = 2'd2;

  localparam logic [1:0] STATUS_NONE     = 2'd0;
  localparam logic [1:0] STATUS_COMPLETE = 2'd1;
  localparam logic [1:0] STATUS_TIMEOUT  = 2'd2;

  typedef enum logic [2:0] {
    PH_SYNC0 = 3'd0,
    PH_SYNC1 = 3'd1,
    PH_CMD   = 3'd2,
    PH_LEN   = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  typedef struct packed {
    logic [15:0] byte_gap_limit;
    logic [5:0]  max_payload;
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  rx_byte;
    logic [15:0] wait_ticks;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       link_lost;
    logic [7:0] frame_cmd;
    logic [7:0] frame_len;
    logic       data_valid;
    logic [5:0] data_index;
    logic [7:0] data_byte;
    logic       frame_error;
  } result_t;

endpackage

// ===== hdl/frr_cfg_regs.sv =====
module frr_cfg_regs (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output frr_pkg::cfg_t   cfg
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.byte_gap_limit <= frr_pkg::GAP_LIMIT_RESET;
      cfg.max_payload    <= frr_pkg::MAX_PAYLOAD_RESET;
      cfg.sync_first     <= frr_pkg::SYNC_FIRST_RESET;
      cfg.sync_second    <= frr_pkg::SYNC_SECOND_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        frr_pkg::REG_GAP_LIMIT:   cfg.byte_gap_limit <= cfg_data;
        frr_pkg::REG_MAX_PAYLOAD: cfg.max_payload    <= cfg_data[5:0];
        frr_pkg::REG_SYNC_FIRST:  cfg.sync_first     <= cfg_data[7:0];
        frr_pkg::REG_SYNC_SECOND: cfg.sync_second    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/frr_in_stage.sv =====
module frr_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  frr_pkg::item_t   in_item,
  output logic             item_valid,
  output frr_pkg::item_t   item,
  input  logic             item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/frr_engine.sv =====
module frr_engine (
  input  logic              clk,
  input  logic              rst,
  input  frr_pkg::cfg_t     cfg,
  input  logic              item_valid,
  input  frr_pkg::item_t    item,
  output logic              item_take,
  output logic              res_valid,
  input  logic              res_ready,
  output frr_pkg::result_t  res
);

  frr_pkg::phase_t  phase, phase_next;
  logic [7:0]       held_cmd, held_cmd_next;
  logic [7:0]       held_len, held_len_next;
  logic [5:0]       byte_count, byte_count_next;
  logic [15:0]      gap_timer, gap_timer_next;
  logic [15:0]      wait_timer, wait_timer_next;
  logic [15:0]      wait_limit, wait_limit_next;
  logic             lost_flag, lost_flag_next;
  frr_pkg::result_t res_next;

  logic [7:0]  len_limit;
  logic        restart;
  logic        complete;
  logic        drop;
  logic        timeout;
  logic [5:0]  count_inc;
  logic [15:0] gap_inc;
  logic [15:0] wait_inc;

  assign item_take = item_valid && (!res_valid || res_ready);
  assign len_limit = ({2'b00, cfg.max_payload} < 8'(frr_pkg::PAYLOAD_MAX)) ?
                     {2'b00, cfg.max_payload} : 8'(frr_pkg::PAYLOAD_MAX);
  assign count_inc = byte_count + 6'd1;
  assign gap_inc   = gap_timer + 16'd1;
  assign wait_inc  = wait_timer + 16'd1;

  // next state
  always_comb begin
    phase_next      = phase;
    held_cmd_next   = held_cmd;
    held_len_next   = held_len;
    byte_count_next = byte_count;
    gap_timer_next  = gap_timer;
    wait_timer_next = wait_timer;
    wait_limit_next = wait_limit;
    lost_flag_next  = lost_flag;
    restart         = 1'b0;
    complete        = 1'b0;
    drop            = 1'b0;
    timeout         = 1'b0;

    case (item.mode)
      frr_pkg::MODE_BYTE: begin
        gap_timer_next = '0;
        case (phase)
          frr_pkg::PH_SYNC1: begin
            if (item.rx_byte == cfg.sync_second) begin
              phase_next = frr_pkg::PH_CMD;
            end else begin
              drop    = 1'b1;
              restart = 1'b1;
            end
          end
          frr_pkg::PH_CMD: begin
            held_cmd_next = item.rx_byte;
            phase_next    = frr_pkg::PH_LEN;
          end
          frr_pkg::PH_LEN: begin
            held_len_next = item.rx_byte;
            if (item.rx_byte == 8'd0) begin
              complete = 1'b1;
              restart  = 1'b1;
            end else if (item.rx_byte <= len_limit) begin
              phase_next      = frr_pkg::PH_DATA;
              byte_count_next = '0;
            end else begin
              drop    = 1'b1;
              restart = 1'b1;
            end
          end
          frr_pkg::PH_DATA: begin
            byte_count_next = count_inc;
            if ({2'b00, count_inc} == held_len) begin
              complete = 1'b1;
              restart  = 1'b1;
            end
          end
          default: begin
            phase_next = (item.rx_byte == cfg.sync_first) ? frr_pkg::PH_SYNC1 :
                                                             frr_pkg::PH_SYNC0;
          end
        endcase
        if (complete) begin
          lost_flag_next = 1'b0;
        end
      end
      frr_pkg::MODE_TICK: begin
        if (gap_timer < cfg.byte_gap_limit) begin
          gap_timer_next = gap_inc;
          if (gap_inc == cfg.byte_gap_limit) begin
            restart = 1'b1;
          end
        end
        if (wait_timer < wait_limit) begin
          wait_timer_next = wait_inc;
          if (wait_inc == wait_limit) begin
            timeout        = 1'b1;
            lost_flag_next = 1'b1;
            restart        = 1'b1;
          end
        end
      end
      frr_pkg::MODE_ARM: begin
        wait_timer_next = '0;
        wait_limit_next = item.wait_ticks;
      end
      default: ;
    endcase

    if (restart) begin
      phase_next      = frr_pkg::PH_SYNC0;
      byte_count_next = '0;
      gap_timer_next  = cfg.byte_gap_limit;
    end
  end

  // result
  always_comb begin
    res_next             = '0;
    res_next.link_lost   = lost_flag_next;
    res_next.frame_cmd   = held_cmd_next;
    res_next.frame_len   = held_len_next;
    res_next.frame_error = drop;
    if (timeout) begin
      res_next.status = frr_pkg::STATUS_TIMEOUT;
    end else if (complete) begin
      res_next.status = frr_pkg::STATUS_COMPLETE;
    end
    if (item.mode == frr_pkg::MODE_BYTE && phase == frr_pkg::PH_DATA) begin
      res_next.data_valid = 1'b1;
      res_next.data_index = byte_count;
      res_next.data_byte  = item.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= frr_pkg::PH_SYNC0;
      held_cmd   <= '0;
      held_len   <= '0;
      byte_count <= '0;
      gap_timer  <= frr_pkg::GAP_LIMIT_RESET;
      wait_timer <= '0;
      wait_limit <= '0;
      lost_flag  <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (item_take) begin
        phase      <= phase_next;
        held_cmd   <= held_cmd_next;
        held_len   <= held_len_next;
        byte_count <= byte_count_next;
        gap_timer  <= gap_timer_next;
        wait_timer <= wait_timer_next;
        wait_limit <= wait_limit_next;
        lost_flag  <= lost_flag_next;
      end
      if (item_take) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/framed_response_receiver_unit.sv =====
// order: a transaction accepted at the input is registered in the input stage, then the
// engine processes it and offers its registered result on the outputs
// throughput: one transaction per cycle unless out_ready stalls the result
// reset: synchronous, clears both stages, loads register defaults and the receiver state;
// the block accepts transactions in the first cycle after reset
module framed_response_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [7:0]  rx_byte,
  input  logic [15:0] wait_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic        link_lost,
  output logic [7:0]  frame_cmd,
  output logic [7:0]  frame_len,
  output logic        data_valid,
  output logic [5:0]  data_index,
  output logic [7:0]  data_byte,
  output logic        frame_error
);

  frr_pkg::cfg_t    cfg;
  frr_pkg::item_t   in_item;
  frr_pkg::item_t   item;
  frr_pkg::result_t res;
  logic             item_valid;
  logic             item_take;

  assign in_item.mode       = mode;
  assign in_item.rx_byte    = rx_byte;
  assign in_item.wait_ticks = wait_ticks;

  frr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  frr_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  frr_engine u_engine (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take),
    .res_valid  (out_valid),
    .res_ready  (out_ready),
    .res        (res)
  );

  assign status      = res.status;
  assign link_lost   = res.link_lost;
  assign frame_cmd   = res.frame_cmd;
  assign frame_len   = res.frame_len;
  assign data_valid  = res.data_valid;
  assign data_index  = res.data_index;
  assign data_byte   = res.data_byte;
  assign frame_error = res.frame_error;

endmodule

// ===== verif/frr_checker.sv =====
module frr_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        mode,
  input  logic [7:0]        rx_byte,
  input  logic [15:0]       wait_ticks,
  input  logic              out_valid,
  input  logic              out_ready,
  input  frr_pkg::result_t  seen,
  output int                mismatches,
  output int                results_due
);

  frr_pkg::cfg_t    regs;
  frr_pkg::phase_t  ph;
  logic [7:0]       cmd_q;
  logic [7:0]       len_q;
  logic [5:0]       count_q;
  logic [15:0]      gap_q;
  logic [15:0]      wait_q;
  logic [15:0]      wait_lim_q;
  logic             lost_q;
  frr_pkg::result_t expected_resp[$];

  function automatic void rx_restart();
    ph      = frr_pkg::PH_SYNC0;
    count_q = '0;
    gap_q   = regs.byte_gap_limit;
  endfunction

  function automatic frr_pkg::result_t predict_response(input frr_pkg::item_t it);
    frr_pkg::result_t r;
    logic [5:0]       cap;
    r   = '0;
    cap = regs.max_payload;
    if (cap > frr_pkg::PAYLOAD_MAX) cap = 6'(frr_pkg::PAYLOAD_MAX);
    case (it.mode)
      frr_pkg::MODE_BYTE: begin
        gap_q = '0;
        case (ph)
          frr_pkg::PH_SYNC1: begin
            if (it.rx_byte == regs.sync_second) begin
              ph = frr_pkg::PH_CMD;
            end else begin
              r.frame_error = 1'b1;
              rx_restart();
            end
          end
          frr_pkg::PH_CMD: begin
            cmd_q = it.rx_byte;
            ph    = frr_pkg::PH_LEN;
          end
          frr_pkg::PH_LEN: begin
            len_q = it.rx_byte;
            if (it.rx_byte == '0) begin
              r.status = frr_pkg::STATUS_COMPLETE;
              rx_restart();
            end else if (it.rx_byte <= cap) begin
              ph      = frr_pkg::PH_DATA;
              count_q = '0;
            end else begin
              r.frame_error = 1'b1;
              rx_restart();
            end
          end
          frr_pkg::PH_DATA: begin
            r.data_valid = 1'b1;
            r.data_index = count_q;
            r.data_byte  = it.rx_byte;
            count_q      = count_q + 6'd1;
            if ({2'b00, count_q} == len_q) begin
              r.status = frr_pkg::STATUS_COMPLETE;
              rx_restart();
            end
          end
          default: ph = (it.rx_byte == regs.sync_first) ? frr_pkg::PH_SYNC1 :
                                                           frr_pkg::PH_SYNC0;
        endcase
        if (r.status == frr_pkg::STATUS_COMPLETE) lost_q = 1'b0;
      end
      frr_pkg::MODE_TICK: begin
        if (gap_q < regs.byte_gap_limit) begin
          gap_q = gap_q + 16'd1;
          if (gap_q == regs.byte_gap_limit) rx_restart();
        end
        if (wait_q < wait_lim_q) begin
          wait_q = wait_q + 16'd1;
          if (wait_q == wait_lim_q) begin
            r.status = frr_pkg::STATUS_TIMEOUT;
            lost_q   = 1'b1;
            rx_restart();
          end
        end
      end
      frr_pkg::MODE_ARM: begin
        wait_q     = '0;
        wait_lim_q = it.wait_ticks;
      end
      default: ;
    endcase
    r.link_lost = lost_q;
    r.frame_cmd = cmd_q;
    r.frame_len = len_q;
    return r;
  endfunction

  always @(posedge clk) begin
    frr_pkg::result_t exp_r;
    if (rst) begin
      regs = {frr_pkg::GAP_LIMIT_RESET, frr_pkg::MAX_PAYLOAD_RESET,
              frr_pkg::SYNC_FIRST_RESET, frr_pkg::SYNC_SECOND_RESET};
      cmd_q      = '0;
      len_q      = '0;
      wait_q     = '0;
      wait_lim_q = '0;
      lost_q     = 1'b0;
      rx_restart();
      expected_resp.delete();
      mismatches  = 0;
      results_due = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: status %0d cmd %02h len %02h",
                     seen.status, seen.frame_cmd, seen.frame_len);
        end else begin
          exp_r = expected_resp.pop_front();
          if (seen !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch: expected st %0d lost %0d cmd %02h len %02h dv %0d ",
                        "idx %0d byte %02h err %0d, got st %0d lost %0d cmd %02h len %02h ",
                        "dv %0d idx %0d byte %02h err %0d"},
                       exp_r.status, exp_r.link_lost, exp_r.frame_cmd, exp_r.frame_len,
                       exp_r.data_valid, exp_r.data_index, exp_r.data_byte,
                       exp_r.frame_error,
                       seen.status, seen.link_lost, seen.frame_cmd, seen.frame_len,
                       seen.data_valid, seen.data_index, seen.data_byte, seen.frame_error);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          frr_pkg::REG_GAP_LIMIT:   regs.byte_gap_limit = cfg_data;
          frr_pkg::REG_MAX_PAYLOAD: regs.max_payload    = cfg_data[5:0];
          frr_pkg::REG_SYNC_FIRST:  regs.sync_first     = cfg_data[7:0];
          frr_pkg::REG_SYNC_SECOND: regs.sync_second    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_resp.push_back(predict_response({mode, rx_byte, wait_ticks}));
      results_due = expected_resp.size();
    end
  end

endmodule

// ===== verif/tb.sv =====
module tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 250;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  mode;
  logic [7:0]  rx_byte;
  logic [15:0] wait_ticks;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  status;
  logic        link_lost;
  logic [7:0]  frame_cmd;
  logic [7:0]  frame_len;
  logic        data_valid;
  logic [5:0]  data_index;
  logic [7:0]  data_byte;
  logic        frame_error;

  int          mismatches;
  int          results_due;
  int          cycles = 0;
  int          sent = 0;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;

  logic [5:0]  cur_max;
  logic [7:0]  cur_s1;
  logic [7:0]  cur_s2;

  framed_response_receiver_unit u_top (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .rx_byte, .wait_ticks,
    .out_valid, .out_ready, .status, .link_lost, .frame_cmd, .frame_len,
    .data_valid, .data_index, .data_byte, .frame_error
  );

  frr_checker u_check (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .mode, .rx_byte, .wait_ticks,
    .out_valid, .out_ready,
    .seen({status, link_lost, frame_cmd, frame_len, data_valid, data_index, data_byte,
           frame_error}),
    .mismatches, .results_due
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, occasional long hold-off
  initial begin
    int gap;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_req) begin
        gap = HOLD_CYCLES;
        hold_req = 1'b0;
      end else begin
        gap = quiet ? 0 : $urandom_range(0, 16);
      end
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [1:0] m, input logic [7:0] b, input logic [15:0] t);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    rx_byte    <= b;
    wait_ticks <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    if (m != MODE_UNUSED) sent++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] gap_lim, input logic [5:0] maxp,
                            input logic [7:0] s1, input logic [7:0] s2);
    write_reg(frr_pkg::REG_GAP_LIMIT, gap_lim);
    write_reg(frr_pkg::REG_MAX_PAYLOAD, {10'($urandom), maxp});
    write_reg(frr_pkg::REG_SYNC_FIRST, {8'($urandom), s1});
    write_reg(frr_pkg::REG_SYNC_SECOND, {8'($urandom), s2});
    cfg_valid <= 1'b0;
    cur_max = maxp;
    cur_s1  = s1;
    cur_s2  = s2;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ticks, arms, stray bytes and unused mode, between frames and inside them
  task automatic send_filler();
    int pick;
    logic [15:0] w;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      send_item(frr_pkg::MODE_TICK, 8'($urandom), 16'($urandom));
    end else if (pick < 8) begin
      case ($urandom_range(0, 9))
        0:       w = '0;
        1:       w = 16'($urandom);
        default: w = 16'($urandom_range(1, 40));
      endcase
      send_item(frr_pkg::MODE_ARM, 8'($urandom), w);
    end else if (pick < 9) begin
      send_item(frr_pkg::MODE_BYTE, 8'($urandom), 16'($urandom));
    end else begin
      send_item(MODE_UNUSED, 8'($urandom), 16'($urandom));
    end
  endtask

  task automatic send_frame_byte(input logic [7:0] b);
    if ($urandom_range(0, 7) == 0) send_filler();
    send_item(frr_pkg::MODE_BYTE, b, 16'($urandom));
  endtask

  task automatic send_frame();
    logic [7:0] cap;
    logic [7:0] len;
    int n;
    int pick;
    cap = (cur_max < frr_pkg::PAYLOAD_MAX) ? 8'(cur_max) : 8'(frr_pkg::PAYLOAD_MAX);
    pick = $urandom_range(0, 19);
    if (pick == 0) len = 8'($urandom);
    else if (pick == 1) len = cap;
    else if (pick == 2) len = cap + 8'd1;
    else len = 8'($urandom_range(0, (cap < 8) ? cap : 8));
    n = (len <= cap) ? len : 0;
    if ($urandom_range(0, 29) == 0) n = n / 2;
    send_frame_byte(cur_s1);
    send_frame_byte(($urandom_range(0, 15) == 0) ? 8'($urandom) : cur_s2);
    send_frame_byte(8'($urandom));
    send_frame_byte(len);
    for (int k = 0; k < n; k++) send_frame_byte(8'($urandom));
  endtask

  initial begin
    int target;
    rst        = 1'b1;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    mode       = frr_pkg::MODE_BYTE;
    rx_byte    = '0;
    wait_ticks = '0;
    cur_max    = frr_pkg::MAX_PAYLOAD_RESET;
    cur_s1     = frr_pkg::SYNC_FIRST_RESET;
    cur_s2     = frr_pkg::SYNC_SECOND_RESET;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings: unused mode, empty and one-byte frames, bad sync, oversize, timeout
    send_item(MODE_UNUSED, 8'hFF, 16'hFFFF);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_SECOND_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, 8'hFF, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h00, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_SECOND_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h5A, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h01, '0);
    send_item(frr_pkg::MODE_BYTE, 8'hFF, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h00, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_SECOND_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h01, '0);
    send_item(frr_pkg::MODE_BYTE, 8'(frr_pkg::PAYLOAD_MAX + 1), '0);
    send_item(frr_pkg::MODE_ARM, '0, 16'd1);
    send_item(frr_pkg::MODE_TICK, '0, '0);
    drain();

    // gap timer expiry, both timers on one tick, zero payload limit
    set_config(16'd1, 6'd0, frr_pkg::SYNC_FIRST_RESET, frr_pkg::SYNC_SECOND_RESET);
    send_item(frr_pkg::MODE_ARM, '0, 16'd2);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_TICK, '0, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_TICK, '0, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_FIRST_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, frr_pkg::SYNC_SECOND_RESET, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h00, '0);
    send_item(frr_pkg::MODE_BYTE, 8'h05, '0);
    drain();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: set_config(16'hFFFF, 6'd48, 8'h00, 8'hFF);
        1: set_config(16'd0, 6'd63, 8'hFF, 8'h00);
        2: set_config(16'd1, 6'd1, 8'($urandom), 8'($urandom));
        3: set_config(16'd3, 6'd48, frr_pkg::SYNC_FIRST_RESET, frr_pkg::SYNC_SECOND_RESET);
        4: begin
          cur_s1 = 8'($urandom);
          set_config(16'($urandom_range(2, 40)), 6'($urandom_range(1, 48)), cur_s1, cur_s1);
        end
        5: set_config(16'($urandom_range(1, 200)), 6'($urandom_range(0, 63)),
                      8'($urandom), 8'($urandom));
        default: set_config(frr_pkg::GAP_LIMIT_RESET, frr_pkg::MAX_PAYLOAD_RESET,
                            frr_pkg::SYNC_FIRST_RESET, frr_pkg::SYNC_SECOND_RESET);
      endcase
      quiet = (p == 3);
      if (p == 2 || p == 5) hold_req = 1'b1;
      target = sent + PHASE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 3) == 0) send_filler();
        else send_frame();
      end
      drain();
    end

    repeat (10) @(negedge clk);
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/frr_pkg.sv
hdl/frr_cfg_regs.sv
hdl/frr_in_stage.sv
hdl/frr_engine.sv
hdl/framed_response_receiver_unit.sv
verif/frr_checker.sv
verif/tb.sv
